>>> hdl/msr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msr_pkg;

    // Default build values for the top level parameters
    localparam int HISTORY_DEPTH_DEF    = 4;
    localparam int DUTY_FULL_SCALE_DEF  = 255;
    localparam int STALL_HOLD_MS_DEF    = 500;
    localparam int STALL_TRIGGER_MS_DEF = 1000;
    localparam int DEFAULT_DELAY_MS_DEF = 20;
    localparam int START_SPEED_MIN_DEF  = 41;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Correction clamp, Q.13
    localparam int CORR_LIMIT = 16384;

    // APB address width: eight 32-bit registers
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_S2D_GAIN   = 3'd0,
        REG_RISE_GAIN  = 3'd1,
        REG_FALL_GAIN  = 3'd2,
        REG_NZ_ACCEL   = 3'd3,
        REG_KICK       = 3'd4,
        REG_BRAKE      = 3'd5,
        REG_OVERSPEED  = 3'd6,
        REG_OVER_ACCEL = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] s2d_gain;
        logic [15:0] rise_gain;
        logic [15:0] fall_gain;
        logic [15:0] nz_accel;
        logic [13:0] kick;
        logic [13:0] brake;
        logic [14:0] overspeed;
        logic [14:0] over_accel;
    } t_cfg;

    typedef enum logic [1:0] {
        MODE_FWD   = 2'd0,
        MODE_BWD   = 2'd1,
        MODE_BRAKE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_ZERO  = 2'd1,
        CAUSE_OVER  = 2'd2,
        CAUSE_STALL = 2'd3
    } t_cause;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_BASE,
        S_LIM,
        S_ACC,
        S_CORR,
        S_UPD,
        S_CHECK,
        S_DUTY,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hdl/msr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module msr_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [msr_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [msr_pkg::MUL_B_W-1:0]   i_b,
    output logic signed      [msr_pkg::MUL_P_W-1:0]   o_p
);
    import msr_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    // Registered signed product
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> hdl/msr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module msr_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [msr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output msr_pkg::t_cfg                    o_cfg
);
    import msr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    // Register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.s2d_gain   <= 16'd4096;
            r_cfg.rise_gain  <= 16'd410;
            r_cfg.fall_gain  <= 16'd410;
            r_cfg.nz_accel   <= 16'd41;
            r_cfg.kick       <= 14'd1638;
            r_cfg.brake      <= 14'd1638;
            r_cfg.overspeed  <= 15'd819;
            r_cfg.over_accel <= 15'd410;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_S2D_GAIN:   r_cfg.s2d_gain   <= pwdata[15:0];
                REG_RISE_GAIN:  r_cfg.rise_gain  <= pwdata[15:0];
                REG_FALL_GAIN:  r_cfg.fall_gain  <= pwdata[15:0];
                REG_NZ_ACCEL:   r_cfg.nz_accel   <= pwdata[15:0];
                REG_KICK:       r_cfg.kick       <= pwdata[13:0];
                REG_BRAKE:      r_cfg.brake      <= pwdata[13:0];
                REG_OVERSPEED:  r_cfg.overspeed  <= pwdata[14:0];
                REG_OVER_ACCEL: r_cfg.over_accel <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_S2D_GAIN:   prdata = {16'd0, r_cfg.s2d_gain};
            REG_RISE_GAIN:  prdata = {16'd0, r_cfg.rise_gain};
            REG_FALL_GAIN:  prdata = {16'd0, r_cfg.fall_gain};
            REG_NZ_ACCEL:   prdata = {16'd0, r_cfg.nz_accel};
            REG_KICK:       prdata = {18'd0, r_cfg.kick};
            REG_BRAKE:      prdata = {18'd0, r_cfg.brake};
            REG_OVERSPEED:  prdata = {17'd0, r_cfg.overspeed};
            REG_OVER_ACCEL: prdata = {17'd0, r_cfg.over_accel};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/motor_speed_regulator.sv
`timescale 1ns / 1ps
`default_nettype none
// A zero target goes straight to the output; a reused snapshot goes to the check and,
// unless braked or stalled, the duty step; a new snapshot first passes base, limit,
// accel, correction and update. No tick is taken until idle; the four products of
// an update and the duty scaling all go through one registered multiplier in turn.
// Reset (synchronous, active low) clears the history ring, the cursor and the
// output stage, and loads the register defaults.
module motor_speed_regulator #(
    parameter int HISTORY_DEPTH    = msr_pkg::HISTORY_DEPTH_DEF,
    parameter int DUTY_FULL_SCALE  = msr_pkg::DUTY_FULL_SCALE_DEF,
    parameter int STALL_HOLD_MS    = msr_pkg::STALL_HOLD_MS_DEF,
    parameter int STALL_TRIGGER_MS = msr_pkg::STALL_TRIGGER_MS_DEF,
    parameter int DEFAULT_DELAY_MS = msr_pkg::DEFAULT_DELAY_MS_DEF,
    parameter int START_SPEED_MIN  = msr_pkg::START_SPEED_MIN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // now_ms[31:0], target_speed[47:32], measured_speed[63:48], blind_time[79:64]
    input  wire logic [79:0]                 i_s_tdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // drive_mode[1:0], duty[9:2], brake_cause[11:10], zero pad [15:12]
    output logic [15:0]                      o_m_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [msr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import msr_pkg::*;

    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    t_cfg   w_cfg;
    t_state r_state, n_state;

    // Latched tick
    logic [31:0]        r_now;
    logic signed [15:0] r_tgt, r_spd;
    logic [15:0]        r_blind;

    // History ring
    logic [31:0]        r_snap_time   [HISTORY_DEPTH];
    logic signed [15:0] r_snap_speed  [HISTORY_DEPTH];
    logic signed [15:0] r_snap_target [HISTORY_DEPTH];
    logic signed [15:0] r_snap_base   [HISTORY_DEPTH];
    logic signed [15:0] r_snap_corr   [HISTORY_DEPTH];
    logic signed [15:0] r_snap_kick   [HISTORY_DEPTH];
    logic               r_snap_brake  [HISTORY_DEPTH];
    logic               r_snap_stall  [HISTORY_DEPTH];
    logic [IDX_W-1:0]   r_cursor;

    // Update working registers
    logic [31:0]        r_dt_eff;
    logic signed [16:0] r_dsp;
    logic signed [15:0] r_base;
    logic [47:0]        r_lim;
    logic signed [27:0] r_acc;

    // Result and output stage
    t_mode  r_res_mode;
    logic [7:0] r_res_duty;
    t_cause r_res_cause;
    logic   r_out_valid;
    t_mode  r_out_mode;
    logic [7:0] r_out_duty;
    t_cause r_out_cause;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_mul_p;

    msr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    msr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Ring pointers: newest, previous, next (also oldest)
    logic [IDX_W-1:0] w_prev, w_next;
    assign w_next = (r_cursor == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_cursor + 1'b1;
    assign w_prev = (r_cursor == '0) ? IDX_W'(HISTORY_DEPTH - 1) : r_cursor - 1'b1;

    // Tick-level decisions
    logic        w_accept, w_kneg, w_up, w_hold, w_skip;
    logic [31:0] w_dt;
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_kneg   = r_tgt[15];
    assign w_up     = w_kneg ? (r_spd >= r_tgt) : (r_spd <= r_tgt);
    assign w_dt     = r_now - r_snap_time[r_cursor];
    assign w_hold   = r_snap_stall[r_cursor] && (r_spd == 16'sd0)
                      && (w_dt < 32'(STALL_HOLD_MS));
    assign w_skip   = (r_snap_target[r_cursor] == r_tgt) && (r_snap_speed[r_cursor] == r_spd)
                      && ({16'd0, r_blind} > w_dt);

    // Stall detection over the ring
    logic        w_all_still;
    logic        w_stall;
    logic [31:0] w_span;
    always_comb begin
        w_all_still = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (r_snap_stall[i] || (r_snap_speed[i] != 16'sd0)) w_all_still = 1'b0;
        end
    end
    assign w_span  = r_snap_time[r_cursor] - r_snap_time[w_next];
    assign w_stall = r_snap_stall[r_cursor]
                     || ((r_snap_target[r_cursor] != 16'sd0) && w_all_still
                         && (w_span >= 32'(STALL_TRIGGER_MS)));

    // Newest snapshot duty and its magnitude
    logic signed [17:0] w_pwm;
    logic [17:0]        w_pwm_abs;
    assign w_pwm = 18'(r_snap_base[r_cursor]) + 18'(r_snap_corr[r_cursor])
                   + 18'(r_snap_kick[r_cursor]);
    assign w_pwm_abs = w_pwm[17] ? 18'(-w_pwm) : w_pwm;

    // Snapshot update terms
    logic signed [20:0] w_base_full;
    logic signed [22:0] w_step;
    logic signed [28:0] w_sacc, w_kacc;
    logic               w_integ, w_brake_hit, w_kick_hit;
    logic signed [17:0] w_over;
    logic signed [23:0] w_corr_sum;
    logic signed [15:0] w_corr_new, w_kick_new;
    logic [16:0]        w_tmag;
    logic [20:0]        w_mag;
    logic [7:0]         w_duty;

    assign w_base_full = w_mul_p[31:11];
    assign w_step      = w_mul_p[33:11];
    assign w_kacc      = w_kneg ? -29'(r_acc) : 29'(r_acc);
    assign w_sacc      = w_up ? w_kacc : -w_kacc;
    assign w_integ     = 50'(w_sacc) < $signed({2'b00, r_lim});
    assign w_over      = w_kneg ? (18'(r_tgt) - 18'(r_spd)) : (18'(r_spd) - 18'(r_tgt));
    assign w_brake_hit = ((50'(w_kacc) > $signed({2'b00, r_lim}))
                          && (w_over > $signed({3'b000, w_cfg.over_accel})))
                         || (w_over > $signed({3'b000, w_cfg.overspeed}));
    assign w_tmag      = w_kneg ? 17'(-18'(r_tgt)) : 17'(r_tgt);
    assign w_kick_hit  = (r_snap_speed[w_prev] == 16'sd0) && (r_snap_speed[r_cursor] == 16'sd0)
                         && (r_spd == 16'sd0) && (w_tmag > 17'(START_SPEED_MIN));
    assign w_corr_sum  = 24'(r_snap_corr[r_cursor]) + (w_integ ? 24'(w_step) : 24'sd0);
    assign w_corr_new  = (w_corr_sum > 24'sd16384) ? 16'(CORR_LIMIT)
                       : (w_corr_sum < -24'sd16384) ? -16'(CORR_LIMIT)
                       : 16'(w_corr_sum);
    always_comb begin
        w_kick_new = 16'sd0;
        if (w_up) begin
            if (w_kick_hit) w_kick_new = w_kneg ? -16'({2'b00, w_cfg.kick}) : 16'({2'b00, w_cfg.kick});
        end else if (w_brake_hit) begin
            w_kick_new = w_kneg ? 16'({2'b00, w_cfg.brake}) : -16'({2'b00, w_cfg.brake});
        end
    end
    assign w_mag  = w_mul_p[33:13];
    assign w_duty = (w_mag > 21'(DUTY_FULL_SCALE)) ? 8'(DUTY_FULL_SCALE) : w_mag[7:0];

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_BASE: begin
                w_mul_a = MUL_A_W'(r_tgt);
                w_mul_b = MUL_B_W'({2'b00, w_cfg.s2d_gain});
            end
            S_LIM: begin
                w_mul_a = MUL_A_W'({2'b00, r_dt_eff});
                w_mul_b = MUL_B_W'({2'b00, w_cfg.nz_accel});
            end
            S_ACC: begin
                w_mul_a = MUL_A_W'(r_dsp);
                w_mul_b = MUL_B_W'(1000);
            end
            S_CORR: begin
                w_mul_a = MUL_A_W'(17'(r_tgt) - 17'(r_spd));
                w_mul_b = MUL_B_W'({2'b00, w_up ? w_cfg.rise_gain : w_cfg.fall_gain});
            end
            S_CHECK: begin
                w_mul_a = MUL_A_W'({1'b0, w_pwm_abs});
                w_mul_b = MUL_B_W'({2'b00, 16'(DUTY_FULL_SCALE)});
            end
            default: ;
        endcase
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_tgt == 16'sd0)       n_state = S_OUT;
                else if (w_hold || w_skip) n_state = S_CHECK;
                else                       n_state = S_BASE;
            end
            S_BASE:   n_state = S_LIM;
            S_LIM:    n_state = S_ACC;
            S_ACC:    n_state = S_CORR;
            S_CORR:   n_state = S_UPD;
            S_UPD:    n_state = S_CHECK;
            S_CHECK:  n_state = (r_snap_brake[r_cursor] || w_stall) ? S_OUT : S_DUTY;
            S_DUTY:   n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Tick latch and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now   <= i_s_tdata[31:0];
            r_tgt   <= i_s_tdata[47:32];
            r_spd   <= i_s_tdata[63:48];
            r_blind <= i_s_tdata[79:64];
        end
        if (r_state == S_DECIDE) begin
            r_dt_eff <= (w_dt == 32'd0) ? 32'(DEFAULT_DELAY_MS) : w_dt;
            r_dsp    <= 17'(r_spd) - 17'(r_snap_speed[r_cursor]);
        end
        if (r_state == S_LIM) begin
            r_base <= (w_base_full > 21'sd32767) ? 16'sh7fff
                    : (w_base_full < -21'sd32768) ? 16'sh8000
                    : 16'(w_base_full);
        end
        if (r_state == S_ACC)  r_lim <= w_mul_p[47:0];
        if (r_state == S_CORR) r_acc <= w_mul_p[27:0];
    end

    // History ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_snap_time[i]   <= '0;
                r_snap_speed[i]  <= '0;
                r_snap_target[i] <= '0;
                r_snap_base[i]   <= '0;
                r_snap_corr[i]   <= '0;
                r_snap_kick[i]   <= '0;
                r_snap_brake[i]  <= 1'b0;
                r_snap_stall[i]  <= 1'b0;
            end
        end else begin
            if (r_state == S_DECIDE && r_tgt == 16'sd0) begin
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    r_snap_time[i]   <= r_now;
                    r_snap_speed[i]  <= '0;
                    r_snap_target[i] <= '0;
                    r_snap_base[i]   <= '0;
                    r_snap_corr[i]   <= '0;
                    r_snap_kick[i]   <= '0;
                    r_snap_brake[i]  <= 1'b0;
                    r_snap_stall[i]  <= 1'b0;
                end
            end
            if (r_state == S_UPD) begin
                r_cursor                <= w_next;
                r_snap_time[w_next]     <= r_now;
                r_snap_speed[w_next]    <= r_spd;
                r_snap_target[w_next]   <= r_tgt;
                r_snap_base[w_next]     <= r_base;
                r_snap_corr[w_next]     <= w_corr_new;
                r_snap_kick[w_next]     <= w_kick_new;
                r_snap_brake[w_next]    <= !w_up && w_brake_hit;
                r_snap_stall[w_next]    <= 1'b0;
            end
            // A braked snapshot wins over the stall mark
            if (r_state == S_CHECK && !r_snap_brake[r_cursor] && w_stall) begin
                r_snap_stall[r_cursor] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        priority if (r_state == S_DECIDE) begin
            r_res_mode  <= MODE_BRAKE;
            r_res_duty  <= 8'd0;
            r_res_cause <= CAUSE_ZERO;
        end else if (r_state == S_CHECK) begin
            r_res_mode  <= MODE_BRAKE;
            r_res_duty  <= 8'd0;
            r_res_cause <= r_snap_brake[r_cursor] ? CAUSE_OVER : CAUSE_STALL;
        end else if (r_state == S_DUTY) begin
            r_res_mode  <= (w_pwm[17] && (w_mag != 21'd0)) ? MODE_BWD : MODE_FWD;
            r_res_duty  <= w_duty;
            r_res_cause <= CAUSE_NONE;
        end else begin
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_mode  <= r_res_mode;
            r_out_duty  <= r_res_duty;
            r_out_cause <= r_res_cause;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_cause, r_out_duty, r_out_mode};

    // Checks
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) < HISTORY_DEPTH)
        else $error("ring cursor out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECIDE))
        else $error("sequencer did not start on input transfer");

    a_brake_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_BRAKE) |-> (r_out_duty == 8'd0 && r_out_cause != CAUSE_NONE))
        else $error("brake result with duty or without cause");

    a_drive_no_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode != MODE_BRAKE) |-> (r_out_cause == CAUSE_NONE))
        else $error("drive result carries a brake cause");

endmodule
`default_nettype wire
